// ===== hw/rtl/lsp_pkg.sv =====
// Shared types and constants for the lifetime slot pool fader.
package lsp_pkg;

  // Default pool size and the reset value of the minimum lifetime.
  localparam int unsigned DEF_POOL_SLOTS = 32;
  localparam logic [23:0] MIN_LIFE_RESET = 24'd102;

  // Request operation codes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SPAWN = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result kinds.
  localparam logic KIND_SPAWN = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Opacity of a slot outside its fade window.
  localparam logic [7:0] OPAQUE = 8'hFF;

  // One stored slot record.
  typedef struct packed {
    logic [23:0] time_left;
    logic [23:0] full_life;
    logic [31:0] id;
    logic [7:0]  opacity;
  } slot_rec_t;

  localparam int unsigned REC_W = $bits(slot_rec_t);

endpackage

// ===== hw/rtl/lsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lifetime_slot_pool_fader_unit.sv =====
// Top level of the lifetime slot pool fader.
//
// A request is taken when start is high and busy is low. op selects a tick
// (age every active slot by elapsed), a spawn (grant a slot with lifetime
// life_request, raised to min_lifetime) or a clear (empty the pool).
// Results appear for one cycle each, marked by strobe; last marks the final
// result of a request. The receiver cannot stall, so results are simply
// driven out in order.
// A spawn takes the next unfilled slot while the pool still has one; when
// the pool is full, a one-slot-a-cycle search looks for an inactive slot.
// A tick walks every slot through one shared serial divider: an inactive
// slot is skipped, an active one is read and aged, and a fading one also
// runs the divider; then a second walk reports each aged slot. The walks
// are bound by the single read port of the slot record RAM. A clear and an
// unused op take effect at once with no result. min_lifetime is written
// through cfg_we/cfg_data; the user must write it only while the block is
// idle, as the block itself does not enforce it. Reset empties the pool,
// zeroes the id counter and sets min_lifetime to 102; the slot records need
// no clearing because a slot is read only after a spawn has written it.
module lifetime_slot_pool_fader_unit #(
  parameter int unsigned POOL_SLOTS = lsp_pkg::DEF_POOL_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [23:0] elapsed,
  input  logic [23:0] life_request,
  input  logic        cfg_we,
  input  logic [23:0] cfg_data,
  output logic        strobe,
  output logic        kind,
  output logic [4:0]  slot,
  output logic [31:0] entry_id,
  output logic [7:0]  opacity,
  output logic        expired,
  output logic [5:0]  active_count,
  output logic        last
);

  localparam int unsigned SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned CW = $clog2(POOL_SLOTS + 1);
  localparam logic [SW-1:0] LAST_IDX = SW'(POOL_SLOTS - 1);
  localparam logic [CW-1:0] POOL_CNT = CW'(POOL_SLOTS);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SP_SCAN = 4'd1;
  localparam logic [3:0] ST_SP_WR   = 4'd2;
  localparam logic [3:0] ST_TK_SCAN = 4'd3;
  localparam logic [3:0] ST_TK_READ = 4'd4;
  localparam logic [3:0] ST_TK_CALC = 4'd5;
  localparam logic [3:0] ST_TK_DIV  = 4'd6;
  localparam logic [3:0] ST_TK_WR   = 4'd7;
  localparam logic [3:0] ST_EM_SCAN = 4'd8;
  localparam logic [3:0] ST_EM_READ = 4'd9;

  logic [3:0]            state;
  logic [23:0]           min_lifetime;
  logic [CW-1:0]         filled;
  logic [CW-1:0]         act_cnt;
  logic [POOL_SLOTS-1:0] active;
  logic [POOL_SLOTS-1:0] reported;
  logic [POOL_SLOTS-1:0] exp_bits;
  logic [31:0]           next_id;
  logic [SW-1:0]         idx;
  logic [SW-1:0]         sel;
  logic [SW-1:0]         last_slot;
  logic                  any_rep;
  logic [23:0]           elapsed_r;
  logic [23:0]           life;
  lsp_pkg::slot_rec_t    rec;
  lsp_pkg::slot_rec_t    rd_rec;
  lsp_pkg::slot_rec_t    wr_rec;
  logic [23:0]           rem;
  logic [7:0]            nlow;
  logic [7:0]            quo;
  logic [2:0]            step;

  // Record store control.
  logic                  ram_we;
  logic [SW-1:0]         ram_waddr;

  // Tick arithmetic.
  logic [23:0]           remain;
  logic [25:0]           remain4;
  logic [33:0]           numer;
  logic [24:0]           trial;
  logic                  trial_ge;
  logic [24:0]           trial_sub;

  // Zero-extended views for the narrow output fields.
  logic [SW+4:0]         idx_ext;
  logic [SW+4:0]         sel_ext;
  logic [CW+5:0]         cnt_ext;

  logic                  accept;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Slot records live in one RAM, always read at the walking index.
  lsp_ram #(
    .WIDTH (lsp_pkg::REC_W),
    .DEPTH (POOL_SLOTS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_rec),
    .raddr (idx),
    .rdata (rd_rec)
  );

  // Write port selection: a spawn writes the chosen slot, a tick its walker.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    wr_rec    = rec;
    if (state == ST_SP_WR) begin
      ram_we            = 1'b1;
      ram_waddr         = sel;
      wr_rec.time_left  = life;
      wr_rec.full_life  = life;
      wr_rec.id         = next_id;
      wr_rec.opacity    = lsp_pkg::OPAQUE;
    end else if (state == ST_TK_WR) begin
      ram_we = 1'b1;
    end
  end

  // Remaining time, its fade numerator and one restoring division step.
  assign remain    = rec.time_left - elapsed_r;
  assign remain4   = {remain, 2'b00};
  assign numer     = {remain4, 8'd0} - {8'd0, remain4};
  assign trial     = {rem, nlow[7]};
  assign trial_ge  = (trial >= {1'b0, rec.full_life});
  assign trial_sub = trial - {1'b0, rec.full_life};

  assign idx_ext = {5'd0, idx};
  assign sel_ext = {5'd0, sel};

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_lifetime <= lsp_pkg::MIN_LIFE_RESET;
    end else if (cfg_we) begin
      min_lifetime <= cfg_data;
    end
  end

  // Sequencer, pool state and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      filled   <= '0;
      act_cnt  <= '0;
      active   <= '0;
      reported <= '0;
      next_id  <= '0;
      any_rep  <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            elapsed_r <= elapsed;
            life      <= (life_request > min_lifetime) ? life_request : min_lifetime;
            idx       <= '0;
            unique case (op)
              lsp_pkg::OP_SPAWN: begin
                if (filled < POOL_CNT) begin
                  sel    <= filled[SW-1:0];
                  filled <= filled + 1'b1;
                  state  <= ST_SP_WR;
                end else begin
                  state <= ST_SP_SCAN;
                end
              end
              lsp_pkg::OP_TICK: begin
                reported <= '0;
                any_rep  <= 1'b0;
                state    <= ST_TK_SCAN;
              end
              lsp_pkg::OP_CLEAR: begin
                active  <= '0;
                filled  <= '0;
                act_cnt <= '0;
              end
              default: ;
            endcase
          end
        end

        // Full pool: lowest inactive slot, or slot 0 when all are active.
        ST_SP_SCAN: begin
          if (!active[idx]) begin
            sel   <= idx;
            state <= ST_SP_WR;
          end else if (idx == LAST_IDX) begin
            sel   <= '0;
            state <= ST_SP_WR;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        ST_SP_WR: begin
          active[sel] <= 1'b1;
          next_id     <= next_id + 32'd1;
          strobe      <= 1'b1;
          kind        <= lsp_pkg::KIND_SPAWN;
          slot        <= sel_ext[4:0];
          entry_id    <= next_id;
          opacity     <= lsp_pkg::OPAQUE;
          expired     <= 1'b0;
          last        <= 1'b1;
          if (active[sel]) begin
            active_count <= cnt_ext[5:0];
          end else begin
            act_cnt      <= act_cnt + 1'b1;
            active_count <= cnt_ext[5:0] + 6'd1;
          end
          state <= ST_IDLE;
        end

        // First walk: age each active slot.
        ST_TK_SCAN: begin
          if (active[idx]) begin
            state <= ST_TK_READ;
          end else if (idx == LAST_IDX) begin
            state <= any_rep ? ST_EM_SCAN : ST_IDLE;
            idx   <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        ST_TK_READ: begin
          rec   <= rd_rec;
          state <= ST_TK_CALC;
        end

        ST_TK_CALC: begin
          if (elapsed_r >= rec.time_left) begin
            rec.time_left <= '0;
            rec.opacity   <= '0;
            active[idx]   <= 1'b0;
            exp_bits[idx] <= 1'b1;
            act_cnt       <= act_cnt - 1'b1;
            state         <= ST_TK_WR;
          end else begin
            rec.time_left <= remain;
            exp_bits[idx] <= 1'b0;
            if (remain4 < {2'b00, rec.full_life}) begin
              rem   <= numer[31:8];
              nlow  <= numer[7:0];
              quo   <= '0;
              step  <= '0;
              state <= ST_TK_DIV;
            end else begin
              rec.opacity <= lsp_pkg::OPAQUE;
              state       <= ST_TK_WR;
            end
          end
        end

        // Serial divider: one quotient bit per cycle.
        ST_TK_DIV: begin
          rem  <= trial_ge ? trial_sub[23:0] : trial[23:0];
          nlow <= {nlow[6:0], 1'b0};
          quo  <= {quo[6:0], trial_ge};
          step <= step + 3'd1;
          if (step == 3'd7) begin
            rec.opacity <= {quo[6:0], trial_ge};
            state       <= ST_TK_WR;
          end
        end

        ST_TK_WR: begin
          reported[idx] <= 1'b1;
          last_slot     <= idx;
          any_rep       <= 1'b1;
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= ST_EM_SCAN;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_TK_SCAN;
          end
        end

        // Second walk: report each aged slot with the final count.
        ST_EM_SCAN: begin
          if (reported[idx]) begin
            state <= ST_EM_READ;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        ST_EM_READ: begin
          strobe       <= 1'b1;
          kind         <= lsp_pkg::KIND_TICK;
          slot         <= idx_ext[4:0];
          entry_id     <= rd_rec.id;
          opacity      <= rd_rec.opacity;
          expired      <= exp_bits[idx];
          active_count <= cnt_ext[5:0];
          last         <= (idx == last_slot);
          if (idx == last_slot) begin
            state <= ST_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_EM_SCAN;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign cnt_ext = {6'd0, act_cnt};

endmodule

// ===== hw/rtl/lsp_checker.sv =====
// Port-level checks for the lifetime slot pool fader, bound to the top level.
module lsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  op,
  input logic        strobe,
  input logic        kind,
  input logic [7:0]  opacity,
  input logic        expired,
  input logic        last
);

  // An expiring slot is reported fully transparent.
  assert property (@(posedge clk) disable iff (rst)
    strobe && kind == lsp_pkg::KIND_TICK && expired |-> opacity == 8'd0)
    else $error("expired slot reported with non-zero opacity");

  // A spawn reply is a single, opaque, unexpired result.
  assert property (@(posedge clk) disable iff (rst)
    strobe && kind == lsp_pkg::KIND_SPAWN |-> last && !expired && opacity == lsp_pkg::OPAQUE)
    else $error("malformed spawn reply");

  // A taken spawn keeps the block busy until its reply.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && op == lsp_pkg::OP_SPAWN |=> busy)
    else $error("spawn accepted without going busy");

  // More results of the same request are still to come.
  assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("block idle before its last result");

  // Reset leaves the block idle and silent.
  assert property (@(posedge clk)
    rst |=> !busy && !strobe)
    else $error("block not idle after reset");

endmodule

bind lifetime_slot_pool_fader_unit lsp_checker u_lsp_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .op      (op),
  .strobe  (strobe),
  .kind    (kind),
  .opacity (opacity),
  .expired (expired),
  .last    (last)
);

// ===== tb/lifetime_slot_pool_fader_unit_test.sv =====
// Self-checking testbench for the lifetime slot pool fader unit.
`timescale 1ns / 100ps

module lifetime_slot_pool_fader_unit_test;

  localparam int SLOTS = 32;
  localparam int CYCLE_LIMIT = 1500000;

  // Operation code that the block ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [4:0]  slot;
    logic [31:0] entry_id;
    logic [7:0]  opacity;
    logic        expired;
    logic [5:0]  active_count;
    logic        last;
  } pool_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic [23:0] elapsed;
  logic [23:0] life_request;
  logic        cfg_we;
  logic [23:0] cfg_data;
  logic        strobe;
  logic        kind;
  logic [4:0]  slot;
  logic [31:0] entry_id;
  logic [7:0]  opacity;
  logic        expired;
  logic [5:0]  active_count;
  logic        last;

  // Shadow copy of the pool state.
  logic [23:0] min_life_shadow;
  int          filled_shadow;
  logic        active_shadow[SLOTS];
  logic [23:0] left_shadow[SLOTS];
  logic [23:0] full_shadow[SLOTS];
  logic [31:0] id_shadow[SLOTS];
  logic [7:0]  opac_shadow[SLOTS];
  logic [31:0] next_id_shadow;

  pool_result_t expected_results[$];
  int           mismatch_count;
  int           cycle_count;
  int           send_idle_pct;

  lifetime_slot_pool_fader_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .elapsed(elapsed), .life_request(life_request), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .strobe(strobe), .kind(kind), .slot(slot),
    .entry_id(entry_id), .opacity(opacity), .expired(expired),
    .active_count(active_count), .last(last)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Cycle counter with a timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int count_live();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (active_shadow[i]) n++;
    return n;
  endfunction

  // Works out the results of one request and updates the shadow state.
  task automatic predict_pool_request(input logic [1:0] r_op, input logic [23:0] r_elapsed,
                                      input logic [23:0] r_life);
    int           s;
    int           n;
    int           live;
    int           order[$];
    logic         exp_flag[$];
    logic [23:0]  life;
    logic [23:0]  rem;
    logic [63:0]  rem4;
    pool_result_t res;
    if (r_op == lsp_pkg::OP_SPAWN) begin
      life = (r_life > min_life_shadow) ? r_life : min_life_shadow;
      s = 0;
      if (filled_shadow < SLOTS) begin
        s = filled_shadow;
        filled_shadow++;
      end else begin
        for (int i = SLOTS - 1; i >= 0; i--) if (!active_shadow[i]) s = i;
      end
      id_shadow[s] = next_id_shadow;
      next_id_shadow = next_id_shadow + 32'd1;
      left_shadow[s] = life;
      full_shadow[s] = life;
      opac_shadow[s] = lsp_pkg::OPAQUE;
      active_shadow[s] = 1'b1;
      live = count_live();
      res = '{lsp_pkg::KIND_SPAWN, s[4:0], id_shadow[s], lsp_pkg::OPAQUE, 1'b0, live[5:0],
              1'b1};
      expected_results = {expected_results, res};
    end else if (r_op == lsp_pkg::OP_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) active_shadow[i] = 1'b0;
      filled_shadow = 0;
    end else if (r_op == lsp_pkg::OP_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (active_shadow[i]) begin
          if (r_elapsed >= left_shadow[i]) begin
            left_shadow[i] = '0;
            active_shadow[i] = 1'b0;
            opac_shadow[i] = '0;
            exp_flag = {exp_flag, 1'b1};
          end else begin
            rem = left_shadow[i] - r_elapsed;
            rem4 = 64'(rem) * 4;
            left_shadow[i] = rem;
            if (rem4 < 64'(full_shadow[i]))
              opac_shadow[i] = 8'((rem4 * 255) / 64'(full_shadow[i]));
            else
              opac_shadow[i] = lsp_pkg::OPAQUE;
            exp_flag = {exp_flag, 1'b0};
          end
          order = {order, i};
        end
      end
      live = count_live();
      n = order.size();
      for (int k = 0; k < n; k++) begin
        s = order[k];
        res = '{lsp_pkg::KIND_TICK, s[4:0], id_shadow[s], opac_shadow[s], exp_flag[k],
                live[5:0], k == n - 1};
        expected_results = {expected_results, res};
      end
    end
  endtask

  // Mismatch reporting.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("Mismatch on %s at cycle %0d: got %0h, expected %0h", what, cycle_count, got,
             want);
    mismatch_count++;
  endtask

  // Checks each result against the oldest expectation.
  always @(posedge clk) begin
    pool_result_t want;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result slot", 32'(slot), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (kind !== want.kind) report_mismatch("kind", 32'(kind), 32'(want.kind));
        if (slot !== want.slot) report_mismatch("slot", 32'(slot), 32'(want.slot));
        if (entry_id !== want.entry_id) report_mismatch("entry_id", entry_id, want.entry_id);
        if (opacity !== want.opacity)
          report_mismatch("opacity", 32'(opacity), 32'(want.opacity));
        if (expired !== want.expired)
          report_mismatch("expired", 32'(expired), 32'(want.expired));
        if (active_count !== want.active_count)
          report_mismatch("active_count", 32'(active_count), 32'(want.active_count));
        if (last !== want.last) report_mismatch("last", 32'(last), 32'(want.last));
      end
    end
  end

  // Sends one request, with a random idle gap before it. start stays high
  // after the accepting edge until the next request or an idle cycle.
  task automatic send_request(input logic [1:0] r_op, input logic [23:0] r_elapsed,
                              input logic [23:0] r_life);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    op <= r_op;
    elapsed <= r_elapsed;
    life_request <= r_life;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_pool_request(r_op, r_elapsed, r_life);
  endtask

  // Waits for all results, then lets the block settle before a register write.
  task automatic drain();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_min_life(input logic [23:0] value);
    drain();
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_life_shadow = value;
  endtask

  // Directed: extremes, every op, zero lifetime and slot reuse after a clear.
  task automatic test_directed();
    send_request(lsp_pkg::OP_TICK, 24'd5, 24'd0);
    send_request(lsp_pkg::OP_SPAWN, 24'd0, 24'd0);
    send_request(lsp_pkg::OP_SPAWN, 24'hFFFFFF, 24'hFFFFFF);
    send_request(lsp_pkg::OP_SPAWN, 24'd0, 24'd1000);
    send_request(lsp_pkg::OP_TICK, 24'd0, 24'd0);
    send_request(lsp_pkg::OP_TICK, 24'd760, 24'hFFFFFF);
    send_request(lsp_pkg::OP_TICK, 24'd200, 24'd0);
    send_request(OP_UNUSED, 24'hFFFFFF, 24'hFFFFFF);
    send_request(lsp_pkg::OP_TICK, 24'hFFFFFF, 24'd0);
    send_request(lsp_pkg::OP_CLEAR, 24'd0, 24'd0);
    write_min_life(24'd0);
    send_request(lsp_pkg::OP_SPAWN, 24'd0, 24'd0);
    send_request(lsp_pkg::OP_TICK, 24'd0, 24'd0);
    write_min_life(24'hFFFFFF);
    send_request(lsp_pkg::OP_SPAWN, 24'd0, 24'd3);
    send_request(lsp_pkg::OP_TICK, 24'hFFFFFE, 24'd0);
    send_request(lsp_pkg::OP_CLEAR, 24'd0, 24'd0);
    write_min_life(24'd8);
  endtask

  // Fills the pool past capacity so that free-slot search and slot 0 reuse occur.
  task automatic test_full_pool();
    for (int i = 0; i < 34; i++)
      send_request(lsp_pkg::OP_SPAWN, '0, 24'($urandom_range(4, 60)));
    send_request(lsp_pkg::OP_TICK, 24'd20, 24'd0);
    for (int i = 0; i < 3; i++)
      send_request(lsp_pkg::OP_SPAWN, '0, 24'($urandom_range(4, 60)));
    send_request(lsp_pkg::OP_TICK, 24'hFFFFFF, 24'd0);
    send_request(lsp_pkg::OP_SPAWN, '0, 24'd9);
    send_request(lsp_pkg::OP_CLEAR, '0, '0);
  endtask

  // Random mix, mostly spawns and ticks with realistic times.
  task automatic test_random(input int items);
    int          pick;
    logic [1:0]  r_op;
    logic [23:0] r_el;
    logic [23:0] r_life;
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      r_op = (pick < 50) ? lsp_pkg::OP_SPAWN :
             (pick < 94) ? lsp_pkg::OP_TICK :
             (pick < 97) ? lsp_pkg::OP_CLEAR : OP_UNUSED;
      if ($urandom_range(9) == 0) begin
        r_el = 24'($urandom);
        r_life = 24'($urandom);
      end else begin
        r_el = 24'($urandom_range(0, 120));
        r_life = 24'($urandom_range(0, 1500));
      end
      send_request(r_op, r_el, r_life);
    end
  endtask

  // Stimulus sequence.
  initial begin
    cycle_count = 0;
    mismatch_count = 0;
    send_idle_pct = 21;
    start = 1'b0;
    op = lsp_pkg::OP_TICK;
    elapsed = '0;
    life_request = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    min_life_shadow = lsp_pkg::MIN_LIFE_RESET;
    filled_shadow = 0;
    next_id_shadow = '0;
    for (int i = 0; i < SLOTS; i++) active_shadow[i] = 1'b0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_pool();
    test_random(120);
    send_idle_pct = 83;
    write_min_life(24'd102);
    test_random(120);
    send_idle_pct = 0;
    write_min_life(24'd300);
    test_random(120);

    drain();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lsp_pkg.sv
hw/rtl/lsp_ram.sv
hw/rtl/lifetime_slot_pool_fader_unit.sv
hw/rtl/lsp_checker.sv
tb/lifetime_slot_pool_fader_unit_test.sv
